[hdl/assert_macros.svh]
// assertion helpers, clocked on clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define QYP_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

// checked at every edge, reset included
`define QYP_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`endif

[hdl/qyp_pkg.sv]
package qyp_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int SAMPLE_WIDTH  = 16;
	localparam int TERM_FRAC     = 30;
	localparam int ANG_FRAC      = 24;
	localparam int TABLE_LEN     = 24;
	localparam int NSTAGES       = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

	localparam int TERM_W    = 36;
	localparam int VEC_W     = SAMPLE_WIDTH + 8;
	localparam int ANG_W     = 28;
	localparam int OUT_W     = 16;
	localparam int PITCH_W   = 15;
	localparam int VEC_DN    = (SAMPLE_WIDTH <= TERM_FRAC) ? TERM_FRAC - SAMPLE_WIDTH : 0;
	localparam int VEC_UP    = (SAMPLE_WIDTH > TERM_FRAC) ? SAMPLE_WIDTH - TERM_FRAC : 0;

	localparam int ISQ_STEPS = TERM_FRAC + 1;
	localparam int ISQ_IN_W  = 2 * ISQ_STEPS;
	localparam int ISQ_REM_W = ISQ_STEPS + 4;
	localparam int PITCH_PRE = 2;
	localparam int YAW_DELAY = PITCH_PRE + ISQ_STEPS;

	typedef logic signed [TERM_W-1:0] term_t;
	typedef logic signed [VEC_W-1:0]  vec_t;
	typedef logic signed [ANG_W-1:0]  ang_t;
	typedef logic signed [OUT_W-1:0]  angle_t;

	localparam term_t  TERM_ONE    = term_t'(1) <<< TERM_FRAC;
	localparam ang_t   HALF_PI_ANG = ang_t'(26353589);
	localparam angle_t PI_Q13      = angle_t'(25736);
	localparam angle_t HALF_PI_Q13 = angle_t'(12868);

	localparam ang_t ARC_TABLE [TABLE_LEN] = '{
		ang_t'(13176795), ang_t'(7778716), ang_t'(4110060), ang_t'(2086331),
		ang_t'(1047214), ang_t'(524117), ang_t'(262123), ang_t'(131069),
		ang_t'(65536), ang_t'(32768), ang_t'(16384), ang_t'(8192),
		ang_t'(4096), ang_t'(2048), ang_t'(1024), ang_t'(512),
		ang_t'(256), ang_t'(128), ang_t'(64), ang_t'(32),
		ang_t'(16), ang_t'(8), ang_t'(4), ang_t'(2)
	};

	typedef struct packed {
		logic clamp;
		logic neg;
	} side_t;

	typedef struct packed {
		term_t sin_y;
		term_t cos_y;
		term_t sin_p;
		side_t side;
	} terms_t;

endpackage

[hdl/qyp_in_if.sv]
interface qyp_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic signed [15:0] quat_w;

	modport source(output valid, quat_x, quat_y, quat_z, quat_w, input ready);
	modport sink(input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

[hdl/qyp_out_if.sv]
interface qyp_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] yaw_angle;
	logic signed [14:0] pitch_angle;
	logic               pitch_clamped;

	modport source(output valid, yaw_angle, pitch_angle, pitch_clamped, input ready);
	modport sink(input valid, yaw_angle, pitch_angle, pitch_clamped, output ready);
endinterface

[hdl/qyp_terms.sv]
module qyp_terms (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_i,
	input  logic signed [15:0] qx,
	input  logic signed [15:0] qy,
	input  logic signed [15:0] qz,
	input  logic signed [15:0] qw,
	output logic               valid_o,
	output qyp_pkg::terms_t    terms_o
);
	import qyp_pkg::*;

	logic               v_s1;
	logic signed [31:0] wz_s1, xy_s1, yy_s1, zz_s1, wy_s1, zx_s1;
	term_t              sy, cy, sp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			valid_o <= 1'b0;
		end else if (en) begin
			v_s1    <= valid_i;
			valid_o <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wz_s1 <= qw * qz;
			xy_s1 <= qx * qy;
			yy_s1 <= qy * qy;
			zz_s1 <= qz * qz;
			wy_s1 <= qw * qy;
			zx_s1 <= qz * qx;
		end
	end

	always_comb begin
		sy = (term_t'(wz_s1) + term_t'(xy_s1)) <<< 1;
		cy = TERM_ONE - ((term_t'(yy_s1) + term_t'(zz_s1)) <<< 1);
		sp = (term_t'(wy_s1) - term_t'(zx_s1)) <<< 1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			terms_o.sin_y      <= sy;
			terms_o.cos_y      <= cy;
			terms_o.sin_p      <= sp;
			terms_o.side.clamp <= (sp >= TERM_ONE) || (sp <= -TERM_ONE);
			terms_o.side.neg   <= sp[TERM_W-1];
		end
	end

endmodule

[hdl/qyp_isqrt.sv]
module qyp_isqrt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            valid_i,
	input  logic [qyp_pkg::ISQ_IN_W-1:0]    n_i,
	input  qyp_pkg::term_t                  tag_i,
	output logic                            valid_o,
	output logic [qyp_pkg::ISQ_STEPS-1:0]   root_o,
	output qyp_pkg::term_t                  tag_o
);
	import qyp_pkg::*;

	logic                  vld_s  [ISQ_STEPS+1];
	logic [ISQ_IN_W-1:0]   n_s    [ISQ_STEPS+1];
	logic [ISQ_REM_W-1:0]  rem_s  [ISQ_STEPS+1];
	logic [ISQ_STEPS-1:0]  root_s [ISQ_STEPS+1];
	term_t                 tag_s  [ISQ_STEPS+1];

	assign vld_s[0]  = valid_i;
	assign n_s[0]    = n_i;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign tag_s[0]  = tag_i;

	for (genvar i = 0; i < ISQ_STEPS; i++) begin : g_step
		logic [ISQ_REM_W-1:0] pre, trial;
		logic                 take;

		always_comb begin
			pre   = {rem_s[i][ISQ_REM_W-3:0], n_s[i][ISQ_IN_W-1 -: 2]};
			trial = ISQ_REM_W'({root_s[i], 2'b01});
			take  = pre >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[i+1]    <= n_s[i] << 2;
				rem_s[i+1]  <= take ? pre - trial : pre;
				root_s[i+1] <= {root_s[i][ISQ_STEPS-2:0], take};
				tag_s[i+1]  <= tag_s[i];
			end
		end
	end

	assign valid_o = vld_s[ISQ_STEPS];
	assign root_o  = root_s[ISQ_STEPS];
	assign tag_o   = tag_s[ISQ_STEPS];

endmodule

[hdl/qyp_cordic.sv]
module qyp_cordic (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_i,
	input  qyp_pkg::term_t  y_i,
	input  qyp_pkg::term_t  x_i,
	input  qyp_pkg::side_t  tag_i,
	input  qyp_pkg::angle_t lim,
	output logic            valid_o,
	output qyp_pkg::angle_t angle_o,
	output qyp_pkg::side_t  tag_o
);
	import qyp_pkg::*;

	localparam int WIDE_W = TERM_W + VEC_UP;

	logic signed [WIDE_W-1:0] xw, yw;
	vec_t                     xv, yv, xr, yr;
	ang_t                     zr;

	logic  vld_s  [NSTAGES+1];
	vec_t  cx_s   [NSTAGES+1];
	vec_t  cy_s   [NSTAGES+1];
	ang_t  cz_s   [NSTAGES+1];
	logic  zero_s [NSTAGES+1];
	side_t tag_s  [NSTAGES+1];

	ang_t                   zsel;
	logic signed [ANG_W:0]  q;

	always_comb begin
		xw = WIDE_W'(x_i) <<< VEC_UP;
		yw = WIDE_W'(y_i) <<< VEC_UP;
		xv = VEC_W'(xw >>> VEC_DN);
		yv = VEC_W'(yw >>> VEC_DN);
		xr = xv;
		yr = yv;
		zr = '0;
		if (xv < 0) begin
			if (yv >= 0) begin
				xr = yv;
				yr = -xv;
				zr = HALF_PI_ANG;
			end else begin
				xr = -yv;
				yr = xv;
				zr = -HALF_PI_ANG;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0]   <= xr;
			cy_s[0]   <= yr;
			cz_s[0]   <= zr;
			zero_s[0] <= (xv == 0) && (yv == 0);
			tag_s[0]  <= tag_i;
		end
	end

	for (genvar i = 0; i < NSTAGES; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (cy_s[i] < 0) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - ARC_TABLE[i];
				end else begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + ARC_TABLE[i];
				end
				zero_s[i+1] <= zero_s[i];
				tag_s[i+1]  <= tag_s[i];
			end
		end
	end

	// round to Q3.13, negate, saturate
	always_comb begin
		zsel = zero_s[NSTAGES] ? '0 : cz_s[NSTAGES];
		q    = -(((ANG_W+1)'(zsel) + (ANG_W+1)'(1 <<< (ANG_FRAC-14))) >>> (ANG_FRAC-13));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= vld_s[NSTAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (q > (ANG_W+1)'(lim))
				angle_o <= lim;
			else if (q < -(ANG_W+1)'(lim))
				angle_o <= -lim;
			else
				angle_o <= OUT_W'(q);
			tag_o <= tag_s[NSTAGES];
		end
	end

endmodule

[hdl/quaternion_to_yaw_pitch.sv]
// channel  dir  fields
// quat     in   quat_x, quat_y, quat_z, quat_w   (Q1.15)
// angles   out  yaw_angle (Q3.13), pitch_angle (Q2.13), pitch_clamped
//
// One request per cycle while angles is not stalled. The latency is set by the 31-step
// square root ahead of the pitch CORDIC.
// Reset clears the valid bits only; no warm-up.
// A stall on angles freezes the whole pipeline; quat.ready drops with it.
module quaternion_to_yaw_pitch (
	input logic        clk,
	input logic        arst_n,
	qyp_in_if.sink     quat,
	qyp_out_if.source  angles
);
	import qyp_pkg::*;
	`include "assert_macros.svh"

	logic   en;
	logic   t_valid;
	terms_t terms;

	angle_t yaw_ang;
	side_t  yaw_side;

	logic                  v_s3, v_s4;
	term_t                 mag;
	logic [2*TERM_FRAC-1:0] sq_s3;
	term_t                 sinp_s3, sinp_s4;
	logic [ISQ_IN_W-1:0]   rem_s4;

	logic                  isq_valid;
	logic [ISQ_STEPS-1:0]  root;
	term_t                 isq_sinp;
	term_t                 cosp;

	logic   p_valid;
	angle_t p_ang;

	angle_t dl_ang  [YAW_DELAY];
	side_t  dl_side [YAW_DELAY];

	assign en         = !angles.valid || angles.ready;
	assign quat.ready = en;

	qyp_terms u_terms (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (quat.valid),
		.qx      (quat.quat_x),
		.qy      (quat.quat_y),
		.qz      (quat.quat_z),
		.qw      (quat.quat_w),
		.valid_o (t_valid),
		.terms_o (terms)
	);

	qyp_cordic u_yaw (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (t_valid),
		.y_i     (terms.sin_y),
		.x_i     (terms.cos_y),
		.tag_i   (terms.side),
		.lim     (PI_Q13),
		.valid_o (),
		.angle_o (yaw_ang),
		.tag_o   (yaw_side)
	);

	assign mag = terms.sin_p[TERM_W-1] ? -terms.sin_p : terms.sin_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= t_valid;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3   <= mag[TERM_FRAC-1:0] * mag[TERM_FRAC-1:0];
			sinp_s3 <= terms.sin_p;
			rem_s4  <= (ISQ_IN_W'(1) << (2 * TERM_FRAC)) - ISQ_IN_W'(sq_s3);
			sinp_s4 <= sinp_s3;
		end
	end

	qyp_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (v_s4),
		.n_i     (rem_s4),
		.tag_i   (sinp_s4),
		.valid_o (isq_valid),
		.root_o  (root),
		.tag_o   (isq_sinp)
	);

	assign cosp = term_t'(root);

	qyp_cordic u_pitch (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (isq_valid),
		.y_i     (isq_sinp),
		.x_i     (cosp),
		.tag_i   ('0),
		.lim     (HALF_PI_Q13),
		.valid_o (p_valid),
		.angle_o (p_ang),
		.tag_o   ()
	);

	// yaw waits for the square root
	always_ff @(posedge clk) begin
		if (en) begin
			dl_ang[0]  <= yaw_ang;
			dl_side[0] <= yaw_side;
			for (int i = 1; i < YAW_DELAY; i++) begin
				dl_ang[i]  <= dl_ang[i-1];
				dl_side[i] <= dl_side[i-1];
			end
		end
	end

	assign angles.valid         = p_valid;
	assign angles.yaw_angle     = dl_ang[YAW_DELAY-1];
	assign angles.pitch_clamped = dl_side[YAW_DELAY-1].clamp;
	assign angles.pitch_angle   = !dl_side[YAW_DELAY-1].clamp ? PITCH_W'(p_ang) :
		dl_side[YAW_DELAY-1].neg ? PITCH_W'(HALF_PI_Q13) : PITCH_W'(-HALF_PI_Q13);

	`QYP_ASSERT(a_clamp_val, angles.valid && angles.pitch_clamped |->
		angles.pitch_angle == PITCH_W'(HALF_PI_Q13) ||
		angles.pitch_angle == PITCH_W'(-HALF_PI_Q13))
	`QYP_ASSERT(a_yaw_range, angles.valid |->
		angles.yaw_angle <= PI_Q13 && angles.yaw_angle >= -PI_Q13)
	`QYP_ASSERT(a_stall_keeps, angles.valid && !angles.ready |=> angles.valid)
	`QYP_ASSERT_ALWAYS(a_rst_empty, !arst_n |-> !angles.valid)

endmodule
